// ===== rtl/detl_pkg.sv =====
// shared types and constants for the delayed event timer list
// no dependencies; used by every module of the block but detl_fifo
package detl_pkg;

  localparam int unsigned TIME_W       = 24;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned CMD_Q_DEPTH  = 2;
  localparam int unsigned RES_Q_DEPTH  = 2;

  // opcodes on the input port
  localparam logic [OP_W-1:0] OP_SCHED = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    CMD_SCHED = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] delay;
    logic [ID_W-1:0]   event_id;
    logic [ID_W-1:0]   target_id;
    logic [TIME_W-1:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] out_event;
    logic [ID_W-1:0] out_target;
    logic            dropped;
    logic            last;
  } out_item_t;

  // decoded command handed from front to back
  typedef struct packed {
    cmd_e              kind;
    logic [TIME_W-1:0] tm;
    logic [ID_W-1:0]   ev;
    logic [ID_W-1:0]   tg;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] remaining;
    logic [ID_W-1:0]   ev;
    logic [ID_W-1:0]   tg;
  } entry_t;

endpackage

// ===== rtl/delayed_event_timer_list_top.sv =====
// Delayed event timer list: an ordered list of up to CAPACITY pending events.
// A schedule transaction appends an entry, or returns one dropped result when
// the list is full; a tick subtracts the elapsed time from every entry in list
// order, dispatches each entry that has run out as a result (last set on the
// final one) and closes up the survivors; a clear empties the list. Input
// transactions land in a two-deep command queue and results leave through a
// two-deep result queue. A tick walks the entries in list order, since the
// entry memory's single read port streams one entry per cycle, except while
// the result queue is full and a result is due.
// Depends on detl_pkg, detl_fifo, detl_front and detl_back.
module delayed_event_timer_list_top #(
  parameter int unsigned CAPACITY = detl_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  detl_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output detl_pkg::out_item_t out_item_o
);

  logic                cmd_valid;
  logic                cmd_pop;
  detl_pkg::cmd_t      cmd;
  logic                res_push;
  logic                res_full;
  detl_pkg::out_item_t res;

  detl_front #(
    .DEPTH (detl_pkg::CMD_Q_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  detl_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  detl_fifo #(
    .T     (detl_pkg::out_item_t),
    .DEPTH (detl_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

  // back end never pushes a result into a full queue
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // back end only takes commands that are there
  a_cmd_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // a refused schedule is always a transaction's only result
  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.dropped) |-> res.last)
    else $error("dropped result without last");

endmodule

// ===== rtl/detl_fifo.sv =====
// small first-in first-out queue of a packed type
// depends on nothing; used for the command queue and the result queue
module detl_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T               mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/detl_front.sv =====
// front end: decodes input transactions into commands and queues them
// depends on detl_pkg and detl_fifo
module detl_front #(
  parameter int unsigned DEPTH = detl_pkg::CMD_Q_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  detl_pkg::in_item_t in_item_i,
  output logic               cmd_valid_o,
  output detl_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  detl_pkg::cmd_t cmd;
  logic           keep;
  logic           cmd_empty;

  always_comb begin
    keep     = 1'b1;
    cmd.kind = detl_pkg::CMD_SCHED;
    cmd.tm   = in_item_i.delay;
    cmd.ev   = in_item_i.event_id;
    cmd.tg   = in_item_i.target_id;
    unique case (in_item_i.opcode)
      detl_pkg::OP_SCHED: cmd.kind = detl_pkg::CMD_SCHED;
      detl_pkg::OP_TICK: begin
        cmd.kind = detl_pkg::CMD_TICK;
        cmd.tm   = in_item_i.elapsed;
      end
      detl_pkg::OP_CLEAR: cmd.kind = detl_pkg::CMD_CLEAR;
      // unused opcode is swallowed here
      default: keep = 1'b0;
    endcase
  end

  detl_fifo #(
    .T     (detl_pkg::cmd_t),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && keep),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== rtl/detl_back.sv =====
// back end: owns the entry memory and carries out schedule, tick and clear
// depends on detl_pkg; feeds the result queue
module detl_back #(
  parameter int unsigned CAPACITY = detl_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  detl_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                res_push_o,
  output detl_pkg::out_item_t res_o,
  input  logic                res_full_i
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  detl_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    wr_q, wr_d;
  logic             proc_v_q, proc_v_d;
  logic             pend_v_q, pend_v_d;
  logic [detl_pkg::ID_W-1:0]   pend_ev_q, pend_ev_d;
  logic [detl_pkg::ID_W-1:0]   pend_tg_q, pend_tg_d;
  logic [detl_pkg::TIME_W-1:0] elapsed_q, elapsed_d;

  detl_pkg::entry_t mem [CAPACITY];
  detl_pkg::entry_t rdata_q;
  detl_pkg::entry_t mem_wdata;
  logic [IW-1:0]    mem_waddr;
  logic             mem_we, mem_re;

  logic due, stall;

  // entry held in the read register is due when the elapsed time covers it
  assign due   = (elapsed_q >= rdata_q.remaining);
  assign stall = proc_v_q && due && pend_v_q && res_full_i;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    proc_v_d  = proc_v_q;
    pend_v_d  = pend_v_q;
    pend_ev_d = pend_ev_q;
    pend_tg_d = pend_tg_q;
    elapsed_d = elapsed_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    unique case (state_q)
      detl_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            detl_pkg::CMD_SCHED: begin
              if (count_q == CW'(CAPACITY)) begin
                if (!res_full_i) begin
                  cmd_pop_o        = 1'b1;
                  res_push_o       = 1'b1;
                  res_o.out_event  = cmd_i.ev;
                  res_o.out_target = cmd_i.tg;
                  res_o.dropped    = 1'b1;
                  res_o.last       = 1'b1;
                end
              end else begin
                cmd_pop_o           = 1'b1;
                mem_we              = 1'b1;
                mem_waddr           = count_q[IW-1:0];
                mem_wdata.remaining = cmd_i.tm;
                mem_wdata.ev        = cmd_i.ev;
                mem_wdata.tg        = cmd_i.tg;
                count_d             = count_q + 1'b1;
              end
            end
            detl_pkg::CMD_TICK: begin
              cmd_pop_o = 1'b1;
              elapsed_d = cmd_i.tm;
              rd_d      = '0;
              wr_d      = '0;
              proc_v_d  = 1'b0;
              pend_v_d  = 1'b0;
              state_d   = detl_pkg::ST_WALK;
            end
            detl_pkg::CMD_CLEAR: begin
              cmd_pop_o = 1'b1;
              count_d   = '0;
            end
            default: ;
          endcase
        end
      end
      detl_pkg::ST_WALK: begin
        if (!proc_v_q && (rd_q == count_q)) begin
          state_d = detl_pkg::ST_DONE;
        end else if (!stall) begin
          if (proc_v_q) begin
            if (due) begin
              // hold the newest due entry back until we know whether it is the final one
              if (pend_v_q) begin
                res_push_o       = 1'b1;
                res_o.out_event  = pend_ev_q;
                res_o.out_target = pend_tg_q;
              end
              pend_v_d  = 1'b1;
              pend_ev_d = rdata_q.ev;
              pend_tg_d = rdata_q.tg;
            end else begin
              // survivor closes up toward the head
              mem_we              = 1'b1;
              mem_waddr           = wr_q[IW-1:0];
              mem_wdata.remaining = rdata_q.remaining - elapsed_q;
              mem_wdata.ev        = rdata_q.ev;
              mem_wdata.tg        = rdata_q.tg;
              wr_d                = wr_q + 1'b1;
            end
          end
          if (rd_q != count_q) begin
            mem_re   = 1'b1;
            rd_d     = rd_q + 1'b1;
            proc_v_d = 1'b1;
          end else begin
            proc_v_d = 1'b0;
          end
        end
      end
      detl_pkg::ST_DONE: begin
        if (!pend_v_q) begin
          count_d = wr_q;
          state_d = detl_pkg::ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.out_event  = pend_ev_q;
          res_o.out_target = pend_tg_q;
          res_o.last       = 1'b1;
          pend_v_d         = 1'b0;
          count_d          = wr_q;
          state_d          = detl_pkg::ST_IDLE;
        end
      end
      default: state_d = detl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= detl_pkg::ST_IDLE;
      count_q  <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      proc_v_q <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      proc_v_q <= proc_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ev_q <= pend_ev_d;
    pend_tg_q <= pend_tg_d;
    elapsed_q <= elapsed_d;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_q[IW-1:0]];
    end
  end

endmodule
